// File: rtl/sgprg_pkg.sv
// ----------------------------------------------------------------------------
// sgprg_pkg
// shared types and constants of the segment glyph pixel run generator
// ----------------------------------------------------------------------------
package sgprg_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_PIXELS_PER_SEGMENT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENTS_PER_DIGIT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIT_COLOR          = 2'd2;

  localparam logic [7:0]  PPS_RESET   = 8'd1;
  localparam logic [2:0]  SPD_RESET   = 3'd7;
  localparam logic [23:0] COLOR_RESET = 24'd38400;

  // item operation codes
  localparam logic [1:0] OP_RENDER = 2'd0;
  localparam logic [1:0] OP_GLYPH  = 2'd1;
  localparam logic [1:0] OP_SYMBOL = 2'd2;

  // preloaded decimal glyphs
  localparam int         DIGIT_COUNT = 10;
  localparam logic [7:0] DIGIT_BASE  = 8'h30;
  localparam logic [6:0] DECIMAL_MASKS [DIGIT_COUNT] = '{
    7'h77, 7'h44, 7'h3E, 7'h6E, 7'h4D, 7'h6B, 7'h7B, 7'h46, 7'h7F, 7'h6F
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_SELECT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic select;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_render;
    logic start_emit;
    logic out_free;
    logic run_last;
  } status_t;

endpackage

// File: rtl/sgprg_ctrl.sv
// ----------------------------------------------------------------------------
// sgprg_ctrl
// sequencer: capture, table compare, entry select, and, while the output is free, one run per cycle
// ----------------------------------------------------------------------------
module sgprg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sgprg_pkg::status_t status,
  output sgprg_pkg::cmd_t    cmd
);
  import sgprg_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (status.is_render) begin
            state_next = ST_COMPARE;
          end
        end
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = ST_SELECT;
      end
      ST_SELECT: begin
        cmd.select = 1'b1;
        state_next = status.start_emit ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.run_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/sgprg_datapath.sv
// ----------------------------------------------------------------------------
// sgprg_datapath
// configuration, glyph and symbol tables, position counter, output register
// ----------------------------------------------------------------------------
module sgprg_datapath #(
  parameter int GLYPH_ENTRIES  = 16,
  parameter int SYMBOL_ENTRIES = 16,
  parameter int LAYOUT_LIMIT   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [sgprg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sgprg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [1:0]                           operation,
  input  logic [7:0]                           character,
  input  logic [6:0]                           segment_mask,
  input  logic [7:0]                           symbol_length,
  input  logic                                 symbol_visible,
  input  logic                                 first_of_string,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [15:0]                          run_start,
  output logic [7:0]                           run_length,
  output logic [23:0]                          run_color,
  output logic                                 last_run,
  input  sgprg_pkg::cmd_t                      cmd,
  output sgprg_pkg::status_t                   status
);
  import sgprg_pkg::*;

  localparam int GCW = $clog2(GLYPH_ENTRIES + 1);
  localparam int SCW = $clog2(SYMBOL_ENTRIES + 1);
  localparam int ECW = $clog2(LAYOUT_LIMIT + 1);
  localparam logic [GCW-1:0] GLYPH_FULL  = GCW'(GLYPH_ENTRIES);
  localparam logic [SCW-1:0] SYMBOL_FULL = SCW'(SYMBOL_ENTRIES);
  localparam logic [ECW-1:0] LAYOUT_FULL = ECW'(LAYOUT_LIMIT);

  // configuration registers
  logic [7:0]  pixels_per_segment;
  logic [2:0]  segments_per_digit;
  logic [23:0] lit_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_per_segment <= PPS_RESET;
      segments_per_digit <= SPD_RESET;
      lit_color          <= COLOR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PIXELS_PER_SEGMENT: pixels_per_segment <= cfg_data[7:0];
        CFG_SEGMENTS_PER_DIGIT: segments_per_digit <= cfg_data[2:0];
        CFG_LIT_COLOR:          lit_color          <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // captured render item
  logic [7:0] char_q;
  logic       first_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      char_q  <= character;
      first_q <= first_of_string;
    end
  end

  // table fill counts
  logic [GCW-1:0] glyph_count;
  logic [SCW-1:0] symbol_count;
  logic           glyph_wr;
  logic           symbol_wr;

  assign glyph_wr  = cmd.capture && (operation == OP_GLYPH) && (glyph_count < GLYPH_FULL);
  assign symbol_wr = cmd.capture && (operation == OP_SYMBOL) && (symbol_count < SYMBOL_FULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_count  <= GCW'(DIGIT_COUNT);
      symbol_count <= '0;
    end else begin
      if (glyph_wr) begin
        glyph_count <= glyph_count + 1'b1;
      end
      if (symbol_wr) begin
        symbol_count <= symbol_count + 1'b1;
      end
    end
  end

  // glyph table, each entry compared in parallel
  logic [6:0]               glyph_mask_w [GLYPH_ENTRIES];
  logic [GLYPH_ENTRIES-1:0] glyph_hit;

  for (genvar gi = 0; gi < GLYPH_ENTRIES; gi++) begin : g_glyph
    localparam logic [GCW-1:0] IDX = GCW'(gi);
    logic [7:0] code;
    logic [6:0] mask;
    logic       wr;

    assign wr = glyph_wr && (glyph_count == IDX);

    if (gi < DIGIT_COUNT) begin : g_preset
      always_ff @(posedge clk) begin
        if (rst) begin
          code <= DIGIT_BASE + 8'(gi);
          mask <= DECIMAL_MASKS[gi];
        end else if (wr) begin
          code <= character;
          mask <= segment_mask;
        end
      end
    end else begin : g_free
      always_ff @(posedge clk) begin
        if (wr) begin
          code <= character;
          mask <= segment_mask;
        end
      end
    end

    assign glyph_mask_w[gi] = mask;
    assign glyph_hit[gi]    = (glyph_count > IDX) && (code == char_q);
  end

  // symbol table, contents undefined until written
  logic [7:0]                symbol_len_w  [SYMBOL_ENTRIES];
  logic [SYMBOL_ENTRIES-1:0] symbol_shown_w;
  logic [SYMBOL_ENTRIES-1:0] symbol_hit;

  for (genvar si = 0; si < SYMBOL_ENTRIES; si++) begin : g_symbol
    localparam logic [SCW-1:0] IDX = SCW'(si);
    logic [7:0] code;
    logic [7:0] len;
    logic       shown;

    always_ff @(posedge clk) begin
      if (symbol_wr && (symbol_count == IDX)) begin
        code  <= character;
        len   <= symbol_length;
        shown <= symbol_visible;
      end
    end

    assign symbol_len_w[si]   = len;
    assign symbol_shown_w[si] = shown;
    assign symbol_hit[si]     = (symbol_count > IDX) && (code == char_q);
  end

  // registered hit vectors, position and element count
  logic [GLYPH_ENTRIES-1:0]  glyph_hit_q;
  logic [SYMBOL_ENTRIES-1:0] symbol_hit_q;
  logic [15:0]               pixel_position;
  logic [ECW-1:0]            element_count;

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      glyph_hit_q  <= glyph_hit;
      symbol_hit_q <= symbol_hit;
    end
  end

  // first hit wins
  logic [GLYPH_ENTRIES-1:0]  glyph_first;
  logic [SYMBOL_ENTRIES-1:0] symbol_first;
  logic [6:0]                sel_mask;
  logic [7:0]                sel_len;
  logic                      sel_shown;
  logic                      glyph_any;
  logic                      symbol_any;
  logic                      layout_full;

  assign glyph_first  = glyph_hit_q & (~glyph_hit_q + 1'b1);
  assign symbol_first = symbol_hit_q & (~symbol_hit_q + 1'b1);
  assign glyph_any    = |glyph_hit_q;
  assign symbol_any   = |symbol_hit_q;
  assign layout_full  = element_count >= LAYOUT_FULL;

  always_comb begin
    sel_mask = '0;
    for (int i = 0; i < GLYPH_ENTRIES; i++) begin
      sel_mask = sel_mask | (glyph_first[i] ? glyph_mask_w[i] : 7'd0);
    end
  end

  always_comb begin
    sel_len   = '0;
    sel_shown = 1'b0;
    for (int i = 0; i < SYMBOL_ENTRIES; i++) begin
      sel_len   = sel_len | (symbol_first[i] ? symbol_len_w[i] : 8'd0);
      sel_shown = sel_shown | (symbol_first[i] & symbol_shown_w[i]);
    end
  end

  // run generator registers
  logic [6:0] cur_bits;
  logic [7:0] cur_len;
  logic [2:0] cur_total;
  logic [2:0] seg_idx;
  logic       run_last;
  logic       element_hit;

  assign element_hit = !layout_full && (glyph_any || symbol_any);
  assign run_last    = (seg_idx + 3'd1) == cur_total;

  always_ff @(posedge clk) begin
    if (cmd.select) begin
      seg_idx   <= '0;
      cur_bits  <= glyph_any ? sel_mask : {6'd0, sel_shown};
      cur_len   <= glyph_any ? pixels_per_segment : sel_len;
      cur_total <= glyph_any ? segments_per_digit : 3'd1;
    end else if (cmd.emit) begin
      seg_idx <= seg_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
      element_count  <= '0;
    end else if (cmd.compare && first_q) begin
      pixel_position <= '0;
      element_count  <= '0;
    end else begin
      if (cmd.select && element_hit) begin
        element_count <= element_count + 1'b1;
      end
      if (cmd.emit) begin
        pixel_position <= pixel_position + {8'd0, cur_len};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      run_start  <= pixel_position;
      run_length <= cur_len;
      run_color  <= cur_bits[seg_idx] ? lit_color : 24'd0;
      last_run   <= run_last;
    end
  end

  assign status.is_render  = operation == OP_RENDER;
  assign status.start_emit = !layout_full &&
                             (glyph_any ? (segments_per_digit != 3'd0) : symbol_any);
  assign status.out_free   = !out_valid || out_ready;
  assign status.run_last   = run_last;

endmodule

// File: rtl/segment_glyph_pixel_run_generator_unit.sv
// ----------------------------------------------------------------------------
// segment_glyph_pixel_run_generator_unit
// character stream to pixel runs for a seven-segment led strip layout
// ----------------------------------------------------------------------------
// Each render transfer looks the character up in the glyph table (preloaded
// with '0'..'9', digits win over symbols, first matching entry wins) and then
// in the symbol table, and sends one run per drawn segment of a digit or a
// single run for a symbol, advancing the strip position as it goes. Register
// transfers (glyph or symbol) leave the block idle and are dropped silently
// when the table is full. A render transfer holds the block until its last
// run is loaded: segments_per_digit runs for a digit, 1 for a symbol, none
// for an unknown character, a full layout or a segments_per_digit of 0. The
// compare state matches the character against every table entry into a
// registered hit vector, the select state picks the first hit, and the run
// generator then loads one run per cycle into the output register while it
// is free. The final run of a character is flagged with last_run, and the
// next item can be taken while that run still waits in the output register.
// The user must write configuration only while the block is idle; the block
// does not enforce it, and there is no memory clearing pass after reset.
// ----------------------------------------------------------------------------
module segment_glyph_pixel_run_generator_unit #(
  parameter int GLYPH_ENTRIES  = 16,
  parameter int SYMBOL_ENTRIES = 16,
  parameter int LAYOUT_LIMIT   = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_write,
  input  logic [sgprg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sgprg_pkg::CFG_DATA_W-1:0]   cfg_data,
  // item channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         operation,
  input  logic [7:0]                         character,
  input  logic [6:0]                         segment_mask,
  input  logic [7:0]                         symbol_length,
  input  logic                               symbol_visible,
  input  logic                               first_of_string,
  // run channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [15:0]                        run_start,
  output logic [7:0]                         run_length,
  output logic [23:0]                        run_color,
  output logic                               last_run
);
  import sgprg_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  sgprg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // tables, position tracking and output register
  sgprg_datapath #(
    .GLYPH_ENTRIES  (GLYPH_ENTRIES),
    .SYMBOL_ENTRIES (SYMBOL_ENTRIES),
    .LAYOUT_LIMIT   (LAYOUT_LIMIT)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .operation       (operation),
    .character       (character),
    .segment_mask    (segment_mask),
    .symbol_length   (symbol_length),
    .symbol_visible  (symbol_visible),
    .first_of_string (first_of_string),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .run_start       (run_start),
    .run_length      (run_length),
    .run_color       (run_color),
    .last_run        (last_run),
    .cmd             (cmd),
    .status          (status)
  );

  // a run is never loaded while a new item may be taken
  a_no_emit_when_idle : assert property (
    @(posedge clk) disable iff (rst) !(in_ready && cmd.emit)
  ) else $error("run emitted while accepting items");

  // a waiting result is never overwritten
  a_no_overwrite : assert property (
    @(posedge clk) disable iff (rst) cmd.emit |-> (!out_valid || out_ready)
  ) else $error("output register overwritten");

  // a render transfer blocks the item channel for the lookup
  a_render_blocks : assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && in_ready && (operation == OP_RENDER)) |=> !in_ready
  ) else $error("item accepted during lookup");

  // an emitted run shows up in the output register next cycle
  a_emit_visible : assert property (
    @(posedge clk) disable iff (rst) cmd.emit |=> out_valid
  ) else $error("emitted run not presented");

endmodule

// File: bench/tb_segment_glyph_pixel_run_generator_unit.sv
// ----------------------------------------------------------------------------
// tb_segment_glyph_pixel_run_generator_unit
// self-checking bench for the segment glyph pixel run generator
// ----------------------------------------------------------------------------
// Character transfers are driven over the item channel while a behavioural
// copy of the glyph and symbol tables, the strip position and the element
// count predicts every pixel run. Runs leaving the block are compared field by
// field with the oldest predicted run. Directed tests cover the preloaded
// digits, table growth and shadowing, register extremes and the layout limit;
// random traffic then runs under three idle patterns, and one long result stall
// at the end backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_segment_glyph_pixel_run_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sgprg_pkg::*;

  // table and layout sizes of the instance
  localparam int GLYPH_SLOTS  = 16;
  localparam int SYMBOL_SLOTS = 16;
  localparam int LAYOUT_SLOTS = 32;

  // the one operation code the package leaves unnamed
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // stretch of the long result stall, in cycles
  localparam int HOLD_OFF_CYCLES = 90;
  // quiet cycles after the last run before the block counts as idle
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic [6:0] mask;
    logic [7:0] slen;
    logic       vis;
    logic       first;
  } char_item_t;

  typedef struct packed {
    logic [15:0] start;
    logic [7:0]  len;
    logic [23:0] color;
    logic        last;
  } pixel_run_t;

  // decimal seven-segment patterns, bit s lights segment s
  localparam logic [6:0] DIGIT_SEGMENTS [10] = '{
    7'h77, 7'h44, 7'h3E, 7'h6E, 7'h4D, 7'h6B, 7'h7B, 7'h46, 7'h7F, 7'h6F
  };

  // ---------------------------------------------------------------------------
  // block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             operation = OP_RENDER;
  logic [7:0]             character = '0;
  logic [6:0]             segment_mask = '0;
  logic [7:0]             symbol_length = '0;
  logic                   symbol_visible = 1'b0;
  logic                   first_of_string = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [15:0]            run_start;
  logic [7:0]             run_length;
  logic [23:0]            run_color;
  logic                   last_run;

  segment_glyph_pixel_run_generator_unit #(
    .GLYPH_ENTRIES  (GLYPH_SLOTS),
    .SYMBOL_ENTRIES (SYMBOL_SLOTS),
    .LAYOUT_LIMIT   (LAYOUT_SLOTS)
  ) u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .character       (character),
    .segment_mask    (segment_mask),
    .symbol_length   (symbol_length),
    .symbol_visible  (symbol_visible),
    .first_of_string (first_of_string),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .run_start       (run_start),
    .run_length      (run_length),
    .run_color       (run_color),
    .last_run        (last_run)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predicted block state: registers, tables, strip position
  // ---------------------------------------------------------------------------
  logic [7:0]  cfg_pps = PPS_RESET;
  logic [2:0]  cfg_spd = SPD_RESET;
  logic [23:0] cfg_color = COLOR_RESET;

  logic [7:0]  glyph_code_tbl [GLYPH_SLOTS];
  logic [6:0]  glyph_mask_tbl [GLYPH_SLOTS];
  int          glyph_used;
  logic [7:0]  sym_code_tbl [SYMBOL_SLOTS];
  logic [7:0]  sym_len_tbl [SYMBOL_SLOTS];
  logic        sym_lit_tbl [SYMBOL_SLOTS];
  int          sym_used;
  logic [15:0] strip_pos;
  int          elements_drawn;

  // runs still owed by the block, oldest first
  pixel_run_t  runs_due [$];

  // bookkeeping
  int          items_sent = 0;     // items handed to the driver
  int          items_offered = 0;  // items the driver has put on the pins
  int          items_taken = 0;    // item transfers seen
  int          runs_seen = 0;
  int          cfg_writes = 0;
  int          mismatches = 0;

  // idle and stall controls, owned by the test sequence
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_off_requests = 0;
  char_item_t  next_item;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------
  task automatic clear_tables();
    int i;
    for (i = 0; i < GLYPH_SLOTS; i++) begin
      glyph_code_tbl[i] = (i < 10) ? 8'h30 + 8'(i) : 8'h00;
      glyph_mask_tbl[i] = (i < 10) ? DIGIT_SEGMENTS[i] : 7'h00;
    end
    for (i = 0; i < SYMBOL_SLOTS; i++) begin
      sym_code_tbl[i] = '0;
      sym_len_tbl[i]  = '0;
      sym_lit_tbl[i]  = 1'b0;
    end
    glyph_used     = 10;
    sym_used       = 0;
    strip_pos      = '0;
    elements_drawn = 0;
  endtask

  // works out the runs one accepted character transfer causes
  task automatic predict_runs(input char_item_t it);
    int         g;
    int         s;
    int         n;
    int         pos_sum;
    bit         hit;
    pixel_run_t r;
    hit = 1'b0;
    case (it.op)
      OP_GLYPH: begin
        // a full table drops the registration
        if (glyph_used < GLYPH_SLOTS) begin
          glyph_code_tbl[glyph_used] = it.ch;
          glyph_mask_tbl[glyph_used] = it.mask;
          glyph_used++;
        end
      end
      OP_SYMBOL: begin
        if (sym_used < SYMBOL_SLOTS) begin
          sym_code_tbl[sym_used] = it.ch;
          sym_len_tbl[sym_used]  = it.slen;
          sym_lit_tbl[sym_used]  = it.vis;
          sym_used++;
        end
      end
      OP_RENDER: begin
        if (it.first) begin
          strip_pos      = '0;
          elements_drawn = 0;
        end
        // once the layout is full nothing more is drawn in this string
        if (elements_drawn < LAYOUT_SLOTS) begin
          // digits first, first matching entry wins
          for (g = 0; g < glyph_used && !hit; g++) begin
            if (glyph_code_tbl[g] == it.ch) begin
              hit = 1'b1;
              n   = int'(cfg_spd);
              for (s = 0; s < n; s++) begin
                pos_sum = int'(strip_pos) + s * int'(cfg_pps);
                r.start = pos_sum[15:0];
                r.len   = cfg_pps;
                r.color = glyph_mask_tbl[g][s] ? cfg_color : 24'h0;
                r.last  = (s == n - 1);
                runs_due.push_back(r);
              end
              pos_sum   = int'(strip_pos) + n * int'(cfg_pps);
              strip_pos = pos_sum[15:0];
              elements_drawn++;
            end
          end
          for (g = 0; g < sym_used && !hit; g++) begin
            if (sym_code_tbl[g] == it.ch) begin
              hit     = 1'b1;
              r.start = strip_pos;
              r.len   = sym_len_tbl[g];
              r.color = sym_lit_tbl[g] ? cfg_color : 24'h0;
              r.last  = 1'b1;
              runs_due.push_back(r);
              pos_sum   = int'(strip_pos) + int'(sym_len_tbl[g]);
              strip_pos = pos_sum[15:0];
              elements_drawn++;
            end
          end
          // unknown characters leave position and count alone
        end
      end
      default: begin
        // unused operation code, ignored by the block
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  task automatic check_run();
    pixel_run_t want;
    runs_seen++;
    if (runs_due.size() == 0) begin
      report_mismatch("run_start of a run nobody asked for", run_start, 0);
      return;
    end
    want = runs_due.pop_front();
    if (run_start !== want.start)  report_mismatch("run_start", run_start, want.start);
    if (run_length !== want.len)   report_mismatch("run_length", run_length, want.len);
    if (run_color !== want.color)  report_mismatch("run_color", run_color, want.color);
    if (last_run !== want.last)    report_mismatch("last_run", last_run, want.last);
  endtask

  // sampling at the rising edge: results are checked before the item taken at
  // the same edge is predicted, since that item's runs cannot have left yet
  always @(posedge clk) begin
    if (rst) begin
      clear_tables();
    end else begin
      if (out_valid && out_ready) check_run();
      if (in_valid && in_ready) begin
        predict_runs('{operation, character, segment_mask, symbol_length,
                       symbol_visible, first_of_string});
        items_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // item driver: one item in flight, payload held until its transfer
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  always @(negedge clk) begin
    if (in_valid && items_taken < items_offered) begin
      // still waiting for the transfer, hold valid and payload
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (items_offered < items_sent) begin
      if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        gap_left = $urandom_range(2);
      end else begin
        operation       <= next_item.op;
        character       <= next_item.ch;
        segment_mask    <= next_item.mask;
        symbol_length   <= next_item.slen;
        symbol_visible  <= next_item.vis;
        first_of_string <= next_item.first;
        in_valid        <= 1'b1;
        items_offered++;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side: random stalls, plus a long hold-off counted here when asked
  int hold_off_left = 0;
  int hold_offs_served = 0;

  always @(negedge clk) begin
    if (hold_offs_served < hold_off_requests) begin
      hold_offs_served++;
      hold_off_left = HOLD_OFF_CYCLES;
    end
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left--;
    end else begin
      out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // shared helpers for the tests
  // ---------------------------------------------------------------------------
  // hands one item to the driver and returns once it has been transferred
  task automatic send_item(input char_item_t it);
    next_item = it;
    items_sent++;
    wait (items_taken >= items_sent);
  endtask

  function automatic char_item_t make_item(input logic [1:0] op, input logic [7:0] ch,
                                           input logic [6:0] mask, input logic [7:0] slen,
                                           input logic vis, input logic first);
    char_item_t it;
    it.op    = op;
    it.ch    = ch;
    it.mask  = mask;
    it.slen  = slen;
    it.vis   = vis;
    it.first = first;
    return it;
  endfunction

  // waits for every owed run, then lets the block's pipeline run dry
  task automatic settle();
    int waited;
    waited = 0;
    while (runs_due.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write while the block is idle; the copy is updated at its edge
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    case (idx)
      CFG_PIXELS_PER_SEGMENT: cfg_pps   = 8'(value);
      CFG_SEGMENTS_PER_DIGIT: cfg_spd   = 3'(value);
      CFG_LIT_COLOR:          cfg_color = 24'(value);
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_layout(input int unsigned pps, input int unsigned spd,
                            input int unsigned color);
    settle();
    write_reg(CFG_PIXELS_PER_SEGMENT, pps);
    write_reg(CFG_SEGMENTS_PER_DIGIT, spd);
    write_reg(CFG_LIT_COLOR, color);
  endtask

  // mostly characters the tables know, some noise and registrations
  function automatic char_item_t rand_item();
    char_item_t it;
    int         pick;
    int         src;
    it.mask  = 7'($urandom_range(127));
    it.slen  = 8'($urandom_range(255));
    it.vis   = 1'($urandom_range(1));
    it.first = ($urandom_range(11) == 0);
    it.ch    = 8'($urandom_range(255));
    pick     = $urandom_range(99);
    if (pick < 80) begin
      it.op = OP_RENDER;
      src   = $urandom_range(9);
      if (src < 6)
        it.ch = glyph_code_tbl[$urandom_range(glyph_used - 1)];
      else if (src < 8 && sym_used > 0)
        it.ch = sym_code_tbl[$urandom_range(sym_used - 1)];
    end else if (pick < 88) begin
      it.op = OP_GLYPH;
    end else if (pick < 96) begin
      it.op = OP_SYMBOL;
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // the ten preloaded digits at reset settings
  task automatic test_preloaded_digits();
    int d;
    for (d = 0; d < 10; d++)
      send_item(make_item(OP_RENDER, 8'h30 + 8'(d), 7'h00, 8'h00, 1'b0, d == 0));
  endtask

  // registrations, shadowed codes, zero-length symbol, unknown and unused items
  task automatic test_table_growth();
    // first_of_string on a registration must not restart the string
    send_item(make_item(OP_GLYPH, "A", 7'h7F, 8'h00, 1'b1, 1'b1));
    send_item(make_item(OP_GLYPH, 8'hFF, 7'h00, 8'hFF, 1'b1, 1'b0));
    send_item(make_item(OP_GLYPH, "5", 7'h01, 8'h00, 1'b0, 1'b0));   // shadowed
    send_item(make_item(OP_SYMBOL, 8'h00, 7'h7F, 8'hFF, 1'b1, 1'b0));
    send_item(make_item(OP_SYMBOL, "-", 7'h00, 8'h00, 1'b0, 1'b1));
    send_item(make_item(OP_SYMBOL, "3", 7'h00, 8'h09, 1'b1, 1'b0));  // digit wins
    send_item(make_item(OP_RENDER, "A", 7'h00, 8'h00, 1'b0, 1'b0));
    send_item(make_item(OP_RENDER, 8'hFF, 7'h00, 8'h00, 1'b0, 1'b0));
    send_item(make_item(OP_RENDER, "5", 7'h00, 8'h00, 1'b0, 1'b0));
    send_item(make_item(OP_RENDER, 8'h00, 7'h7F, 8'hFF, 1'b1, 1'b0));
    send_item(make_item(OP_RENDER, "-", 7'h00, 8'h00, 1'b0, 1'b0));
    send_item(make_item(OP_RENDER, "3", 7'h00, 8'h00, 1'b0, 1'b0));
    send_item(make_item(OP_RENDER, "z", 7'h00, 8'h00, 1'b0, 1'b0));  // unknown
    send_item(make_item(OP_UNUSED, "8", 7'h7F, 8'hFF, 1'b1, 1'b1));
    send_item(make_item(OP_RENDER, "8", 7'h00, 8'h00, 1'b0, 1'b0));
  endtask

  // register extremes, including digits drawn with no segments at all
  task automatic test_register_extremes();
    set_layout(255, 7, 24'hFFFFFF);
    send_item(make_item(OP_RENDER, "8", 7'h00, 8'h00, 1'b0, 1'b1));
    send_item(make_item(OP_RENDER, 8'hFF, 7'h00, 8'h00, 1'b0, 1'b0));
    send_item(make_item(OP_RENDER, 8'h00, 7'h00, 8'h00, 1'b0, 1'b0));
    set_layout(1, 1, 24'h000000);
    send_item(make_item(OP_RENDER, "8", 7'h00, 8'h00, 1'b0, 1'b0));
    send_item(make_item(OP_RENDER, "1", 7'h00, 8'h00, 1'b0, 1'b0));
    // zero segments: the digit counts as an element but moves nothing
    set_layout(200, 0, 24'h123456);
    send_item(make_item(OP_RENDER, "5", 7'h00, 8'h00, 1'b0, 1'b1));
    send_item(make_item(OP_RENDER, "0", 7'h00, 8'h00, 1'b0, 1'b0));
    send_item(make_item(OP_RENDER, 8'h00, 7'h00, 8'h00, 1'b0, 1'b0));
  endtask

  // fill the layout, then show it stays full until a new string starts
  task automatic test_layout_limit();
    int k;
    set_layout(3, 1, 24'hA5005A);
    for (k = 0; k < LAYOUT_SLOTS + 3; k++)
      send_item(make_item(OP_RENDER, (k % 3 == 2) ? 8'h00 : 8'h30 + 8'(k % 10),
                          7'h00, 8'h00, 1'b0, k == 0));
    send_item(make_item(OP_SYMBOL, "q", 7'h00, 8'h04, 1'b1, 1'b1));
    send_item(make_item(OP_RENDER, "7", 7'h00, 8'h00, 1'b0, 1'b0));
    send_item(make_item(OP_RENDER, "7", 7'h00, 8'h00, 1'b0, 1'b1));
  endtask

  // long result stall while characters keep coming, so the block backs up
  task automatic test_backpressure();
    int k;
    set_layout(2, 7, 24'h0F0F0F);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_off_requests++;
    for (k = 0; k < 12; k++)
      send_item(make_item(OP_RENDER, 8'h30 + 8'($urandom_range(9)), 7'h00, 8'h00,
                          1'b0, k == 0));
  endtask

  // random traffic in chunks, each chunk under a fresh register setting
  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
    int k;
    int unsigned pps;
    for (k = 0; k < count; k++) begin
      if (k % 28 == 0) begin
        // mostly short segments, now and then up to the widest
        pps = ($urandom_range(9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
        set_layout(pps, $urandom_range(1, 7), $urandom_range(24'hFFFFFF));
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
      end
      send_item(rand_item());
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_preloaded_digits();
    test_table_growth();
    test_register_extremes();
    test_layout_limit();
    test_random_traffic(19, 48, 55);
    test_random_traffic(48, 19, 55);
    test_random_traffic(0, 0, 55);
    test_backpressure();

    settle();
    if (runs_due.size() > 0)
      report_mismatch("count of runs never produced", runs_due.size(), 0);

    $display("run covered %0d character transfers, %0d register writes, %0d runs checked",
             items_taken, cfg_writes, runs_seen);
    $display("tables ended at %0d/%0d glyphs and %0d/%0d symbols, %0d mismatches",
             glyph_used, GLYPH_SLOTS, sym_used, SYMBOL_SLOTS, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #4000000;
    $display("watchdog expired with %0d runs outstanding", runs_due.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
